FILE: rtl/bfsp_pkg.sv
// ----------------------------------------------------------------------------
// bfsp_pkg
// Shared constants, request codes and controller/datapath interface types
// for the Bellman-Ford shortest path block.
// ----------------------------------------------------------------------------
package bfsp_pkg;

    localparam int DEF_MAX_NODES   = 64;
    localparam int DEF_MAX_EDGES   = 256;
    localparam int DEF_WEIGHT_BITS = 16;

    localparam int REQ_W    = 2;
    localparam int NODE_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int IN_WGT_W = 16;
    localparam int DIST_W   = 33;
    localparam int SUM_W    = DIST_W + 1;
    localparam int OUT_W    = 32;

    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RUN   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    typedef struct packed {
        logic capture;
        logic load_fwd;
        logic load_rev;
        logic clear;
        logic run_init;
        logic dist_rd;
        logic relax;
        logic out_rd;
        logic out_emit;
    } bfsp_cmd_t;

    typedef struct packed {
        logic undirected;
        logic src_ok;
        logic tbl_empty;
        logic edge_last;
        logic check_pass;
        logic node_last;
    } bfsp_sts_t;

endpackage

FILE: rtl/bfsp_ram.sv
// ----------------------------------------------------------------------------
// bfsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/bfsp_ctrl.sv
// ----------------------------------------------------------------------------
// bfsp_ctrl
// Sequencer: decodes requests and steps the datapath through edge loading,
// relaxation passes and result output.
// ----------------------------------------------------------------------------
module bfsp_ctrl
    import bfsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [REQ_W-1:0] req_type,
    input  bfsp_sts_t        st,
    output bfsp_cmd_t        cmd,
    output logic             busy
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD2 = 3'd1;
    localparam logic [2:0] ST_PREP  = 3'd2;
    localparam logic [2:0] ST_ERD   = 3'd3;
    localparam logic [2:0] ST_EEX   = 3'd4;
    localparam logic [2:0] ST_ORD   = 3'd5;
    localparam logic [2:0] ST_OEM   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    case (req_type)
                        REQ_LOAD:
                        begin
                            cmd.load_fwd = 1'b1;
                            if (st.undirected)
                            begin
                                state_next = ST_LOAD2;
                            end
                        end
                        REQ_RUN:
                        begin
                            state_next = ST_PREP;
                        end
                        REQ_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOAD2:
            begin
                cmd.load_rev = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_PREP:
            begin
                cmd.run_init = 1'b1;
                if (!st.src_ok || st.tbl_empty)
                begin
                    state_next = ST_ORD;
                end
                else
                begin
                    state_next = ST_ERD;
                end
            end
            ST_ERD:
            begin
                cmd.dist_rd = 1'b1;
                state_next  = ST_EEX;
            end
            ST_EEX:
            begin
                cmd.relax = 1'b1;
                if (st.edge_last && st.check_pass)
                begin
                    state_next = ST_ORD;
                end
                else
                begin
                    state_next = ST_ERD;
                end
            end
            ST_ORD:
            begin
                cmd.out_rd = 1'b1;
                state_next = ST_OEM;
            end
            ST_OEM:
            begin
                cmd.out_emit = 1'b1;
                if (st.node_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_ORD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/bfsp_dp.sv
// ----------------------------------------------------------------------------
// bfsp_dp
// Datapath: edge table, distance store with valid bits, relaxation
// arithmetic, pass and node counters and the result register.
// ----------------------------------------------------------------------------
module bfsp_dp
    import bfsp_pkg::*;
#(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int MAX_EDGES   = DEF_MAX_EDGES,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bfsp_cmd_t                  cmd,
    output bfsp_sts_t                  st,
    input  logic [NODE_W-1:0]          from_node,
    input  logic [NODE_W-1:0]          to_node,
    input  logic signed [IN_WGT_W-1:0] edge_weight,
    input  logic                       is_directed,
    input  logic [COUNT_W-1:0]         node_count,
    input  logic [NODE_W-1:0]          source_node,
    output logic                       result_strobe,
    output logic [NODE_W-1:0]          node_index,
    output logic signed [OUT_W-1:0]    distance,
    output logic                       reachable,
    output logic                       negative_cycle,
    output logic                       edges_dropped,
    output logic                       last
);

    localparam int NA   = $clog2(MAX_NODES);
    localparam int EA   = $clog2(MAX_EDGES);
    localparam int TW   = EA + 1;
    localparam int EW   = 2 * NODE_W + WEIGHT_BITS;
    localparam int WX   = (WEIGHT_BITS > IN_WGT_W) ? WEIGHT_BITS : IN_WGT_W;
    localparam int W_HI_I = (1 << (WEIGHT_BITS - 1)) - 1;
    localparam logic signed [WX-1:0] W_HI = WX'(W_HI_I);
    localparam logic signed [WX-1:0] W_LO = WX'(-W_HI_I - 1);

    logic signed [WX-1:0]          w_ext;
    logic signed [WX-1:0]          w_sat;
    logic [WEIGHT_BITS-1:0]        w_in;
    logic [COUNT_W-1:0]            n_in;

    logic [NODE_W-1:0]             from_reg;
    logic [NODE_W-1:0]             to_reg;
    logic [WEIGHT_BITS-1:0]        w_reg;
    logic [COUNT_W-1:0]            n_reg;
    logic [NODE_W-1:0]             src_reg;

    logic [TW-1:0]                 total_reg;
    logic [TW-1:0]                 total_next;
    logic                          dropped_reg;
    logic                          dropped_next;
    logic                          append;
    logic                          full;
    logic                          ewe;
    logic [NODE_W-1:0]             app_u;
    logic [NODE_W-1:0]             app_v;
    logic [WEIGHT_BITS-1:0]        app_w;

    logic                          ere;
    logic [EA-1:0]                 eraddr;
    logic [EW-1:0]                 erdata;
    logic [NODE_W-1:0]             eu;
    logic [NODE_W-1:0]             ev;
    logic signed [WEIGHT_BITS-1:0] ew;

    logic [EA-1:0]                 e_reg;
    logic [COUNT_W-1:0]            p_reg;
    logic [NODE_W-1:0]             i_reg;

    logic [MAX_NODES-1:0]          vld_reg;
    logic                          du_vld_reg;
    logic                          dv_vld_reg;
    logic                          neg_reg;

    logic                          da_re;
    logic [NA-1:0]                 da_raddr;
    logic [DIST_W-1:0]             da_rdata;
    logic [DIST_W-1:0]             db_rdata;
    logic                          dwe;
    logic [NA-1:0]                 dwaddr;
    logic [DIST_W-1:0]             dwdata;

    logic signed [DIST_W-1:0]      du;
    logic signed [DIST_W-1:0]      dv;
    logic signed [SUM_W-1:0]       sum;
    logic signed [DIST_W-1:0]      cand;
    logic                          in_range;
    logic                          relax_ok;
    logic                          upd;
    logic [OUT_W-1:0]              dist_out;

    logic                          strobe_reg;
    logic [NODE_W-1:0]             idx_reg;
    logic [OUT_W-1:0]              dist_reg;
    logic                          reach_reg;
    logic                          negc_reg;
    logic                          drop_reg;
    logic                          last_reg;

    // input conditioning
    assign w_ext = WX'(edge_weight);

    always_comb
    begin
        if (w_ext > W_HI)
        begin
            w_sat = W_HI;
        end
        else if (w_ext < W_LO)
        begin
            w_sat = W_LO;
        end
        else
        begin
            w_sat = w_ext;
        end
    end

    assign w_in = w_sat[WEIGHT_BITS-1:0];

    always_comb
    begin
        if (node_count == '0)
        begin
            n_in = COUNT_W'(1);
        end
        else if (node_count > COUNT_W'(MAX_NODES))
        begin
            n_in = COUNT_W'(MAX_NODES);
        end
        else
        begin
            n_in = node_count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            from_reg <= from_node;
            to_reg   <= to_node;
            w_reg    <= w_in;
            n_reg    <= n_in;
            src_reg  <= source_node;
        end
    end

    // edge table append and clear
    assign append = cmd.load_fwd || cmd.load_rev;
    assign full   = (total_reg == TW'(MAX_EDGES));
    assign ewe    = append && !full;
    assign app_u  = cmd.load_fwd ? from_node : to_reg;
    assign app_v  = cmd.load_fwd ? to_node : from_reg;
    assign app_w  = cmd.load_fwd ? w_in : w_reg;

    always_comb
    begin
        total_next   = total_reg;
        dropped_next = dropped_reg;
        if (cmd.clear)
        begin
            total_next   = '0;
            dropped_next = 1'b0;
        end
        else if (ewe)
        begin
            total_next = total_reg + TW'(1);
        end
        else if (append)
        begin
            dropped_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            total_reg   <= total_next;
            dropped_reg <= dropped_next;
        end
    end

    assign ere    = cmd.run_init || cmd.relax;
    assign eraddr = (cmd.run_init || st.edge_last) ? '0 : e_reg + EA'(1);

    bfsp_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (ewe),
        .waddr (total_reg[EA-1:0]),
        .wdata ({app_u, app_v, app_w}),
        .re    (ere),
        .raddr (eraddr),
        .rdata (erdata)
    );

    assign eu = erdata[EW-1 -: NODE_W];
    assign ev = erdata[EW-NODE_W-1 -: NODE_W];
    assign ew = erdata[WEIGHT_BITS-1:0];

    // status
    assign st.undirected = !is_directed;
    assign st.src_ok     = ({1'b0, src_reg} < n_reg);
    assign st.tbl_empty  = (total_reg == '0);
    assign st.edge_last  = ((TW'(e_reg) + TW'(1)) == total_reg);
    assign st.check_pass = (p_reg == (n_reg - COUNT_W'(1)));
    assign st.node_last  = ({1'b0, i_reg} == (n_reg - COUNT_W'(1)));

    // distance store, duplicated for the two read ports
    assign da_re    = cmd.dist_rd || cmd.out_rd;
    assign da_raddr = cmd.out_rd ? i_reg[NA-1:0] : eu[NA-1:0];
    assign dwe      = (cmd.run_init && st.src_ok) || upd;
    assign dwaddr   = cmd.run_init ? src_reg[NA-1:0] : ev[NA-1:0];
    assign dwdata   = cmd.run_init ? '0 : cand;

    bfsp_ram #(
        .WIDTH (DIST_W),
        .DEPTH (MAX_NODES)
    ) u_dist_ram_a (
        .clk   (clk),
        .we    (dwe),
        .waddr (dwaddr),
        .wdata (dwdata),
        .re    (da_re),
        .raddr (da_raddr),
        .rdata (da_rdata)
    );

    bfsp_ram #(
        .WIDTH (DIST_W),
        .DEPTH (MAX_NODES)
    ) u_dist_ram_b (
        .clk   (clk),
        .we    (dwe),
        .waddr (dwaddr),
        .wdata (dwdata),
        .re    (cmd.dist_rd),
        .raddr (ev[NA-1:0]),
        .rdata (db_rdata)
    );

    // relaxation
    assign du  = da_rdata;
    assign dv  = db_rdata;
    assign sum = SUM_W'(du) + SUM_W'(ew);

    always_comb
    begin
        if (sum[SUM_W-1] != sum[SUM_W-2])
        begin
            cand = sum[SUM_W-1] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
        end
        else
        begin
            cand = sum[DIST_W-1:0];
        end
    end

    assign in_range = ({1'b0, eu} < n_reg) && ({1'b0, ev} < n_reg);
    assign relax_ok = in_range && du_vld_reg && (!dv_vld_reg || (cand < dv));
    assign upd      = cmd.relax && relax_ok && !st.check_pass;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_reg      <= '0;
            p_reg      <= '0;
            i_reg      <= '0;
            vld_reg    <= '0;
            du_vld_reg <= 1'b0;
            dv_vld_reg <= 1'b0;
            neg_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.run_init)
            begin
                e_reg   <= '0;
                p_reg   <= '0;
                i_reg   <= '0;
                neg_reg <= 1'b0;
                vld_reg <= st.src_ok ? (MAX_NODES'(1) << src_reg[NA-1:0]) : '0;
            end
            if (cmd.dist_rd)
            begin
                du_vld_reg <= vld_reg[eu[NA-1:0]];
                dv_vld_reg <= vld_reg[ev[NA-1:0]];
            end
            if (cmd.out_rd)
            begin
                du_vld_reg <= vld_reg[i_reg[NA-1:0]];
            end
            if (cmd.relax)
            begin
                if (st.edge_last)
                begin
                    e_reg <= '0;
                    p_reg <= p_reg + COUNT_W'(1);
                end
                else
                begin
                    e_reg <= e_reg + EA'(1);
                end
                if (upd)
                begin
                    vld_reg[ev[NA-1:0]] <= 1'b1;
                end
                if (relax_ok && st.check_pass)
                begin
                    neg_reg <= 1'b1;
                end
            end
            if (cmd.out_emit)
            begin
                i_reg <= i_reg + NODE_W'(1);
            end
        end
    end

    // result register
    always_comb
    begin
        if (!du_vld_reg)
        begin
            dist_out = '0;
        end
        else if (da_rdata[DIST_W-1] != da_rdata[DIST_W-2])
        begin
            dist_out = da_rdata[DIST_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end
        else
        begin
            dist_out = da_rdata[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.out_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_emit)
        begin
            idx_reg   <= i_reg;
            dist_reg  <= dist_out;
            reach_reg <= du_vld_reg;
            negc_reg  <= neg_reg;
            drop_reg  <= dropped_reg;
            last_reg  <= st.node_last;
        end
    end

    assign result_strobe  = strobe_reg;
    assign node_index     = idx_reg;
    assign distance       = dist_reg;
    assign reachable      = reach_reg;
    assign negative_cycle = negc_reg;
    assign edges_dropped  = drop_reg;
    assign last           = last_reg;

endmodule

FILE: rtl/bellman_ford_shortest_paths.sv
// ----------------------------------------------------------------------------
// bellman_ford_shortest_paths
// Single-source shortest paths over a loaded edge table by repeated edge
// relaxation, with negative-cycle detection and one result per node.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  request   start in, busy out        req_type, from_node, to_node,
//                                      edge_weight, is_directed,
//                                      node_count, source_node
//  result    result_strobe out         node_index, distance, reachable,
//                                      negative_cycle, edges_dropped, last
//
//  Directed load and clear do not raise busy; an undirected load appends
//  the reverse edge from a second state. Run: relaxation passes over the
//  edge table, then result output; no passes if the source is out of range
//  or the table is empty. Edge step: distance read, then add, compare, write.
//  Results come one per node, in node order, each strobed for one cycle.
//  Reset clears the edge count, the dropped flag and all control state.
//  The receiver cannot stall; results are never held back.
// ----------------------------------------------------------------------------
module bellman_ford_shortest_paths
    import bfsp_pkg::*;
#(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int MAX_EDGES   = DEF_MAX_EDGES,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [REQ_W-1:0]           req_type,
    input  logic [NODE_W-1:0]          from_node,
    input  logic [NODE_W-1:0]          to_node,
    input  logic signed [IN_WGT_W-1:0] edge_weight,
    input  logic                       is_directed,
    input  logic [COUNT_W-1:0]         node_count,
    input  logic [NODE_W-1:0]          source_node,
    output logic                       result_strobe,
    output logic [NODE_W-1:0]          node_index,
    output logic signed [OUT_W-1:0]    distance,
    output logic                       reachable,
    output logic                       negative_cycle,
    output logic                       edges_dropped,
    output logic                       last
);

    bfsp_cmd_t cmd;
    bfsp_sts_t st;

    bfsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .st       (st),
        .cmd      (cmd),
        .busy     (busy)
    );

    bfsp_dp #(
        .MAX_NODES   (MAX_NODES),
        .MAX_EDGES   (MAX_EDGES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .from_node      (from_node),
        .to_node        (to_node),
        .edge_weight    (edge_weight),
        .is_directed    (is_directed),
        .node_count     (node_count),
        .source_node    (source_node),
        .result_strobe  (result_strobe),
        .node_index     (node_index),
        .distance       (distance),
        .reachable      (reachable),
        .negative_cycle (negative_cycle),
        .edges_dropped  (edges_dropped),
        .last           (last)
    );

endmodule

FILE: rtl/bfsp_chk.sv
// ----------------------------------------------------------------------------
// bfsp_chk
// Port-level checks on request acceptance and result sequencing, bound to
// the top level.
// ----------------------------------------------------------------------------
module bfsp_chk
    import bfsp_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic [REQ_W-1:0]           req_type,
    input logic                       result_strobe,
    input logic [NODE_W-1:0]          node_index,
    input logic signed [OUT_W-1:0]    distance,
    input logic                       reachable,
    input logic                       last
);

    a_run_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_RUN) |=> busy)
        else $error("run transfer did not raise busy");

    a_result_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy))
        else $error("result outside a run");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last) |-> !busy)
        else $error("busy still high at final result");

    a_node_order: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !last) |-> ##2
            (result_strobe && node_index == NODE_W'($past(node_index, 2) + 1'b1)))
        else $error("results out of node order");

    a_unreached_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !reachable) |-> (distance == '0))
        else $error("unreachable node with non-zero distance");

endmodule

bind bellman_ford_shortest_paths bfsp_chk u_bfsp_chk (.*);
